[design/svg_pkg.sv]
// Shared types, constants and arithmetic helpers of the sphere vertex generator.
`timescale 1ns / 1ps
package svg_pkg;

    localparam int FRAC_BITS       = 14;
    localparam int MAX_DIVISIONS   = 256;
    localparam int MIN_SECTORS     = 3;
    localparam int MIN_STACKS      = 2;
    localparam int TRIG_ITERATIONS = 16;
    localparam int DIV_STAGES      = 16;
    localparam int CORDIC_STAGES   = TRIG_ITERATIONS / 2;
    localparam int POS_W           = FRAC_BITS + 1;
    localparam int NORM_W          = FRAC_BITS + 2;

    localparam logic [31:0]        QUARTER_TURN = 32'h4000_0000;
    localparam logic signed [32:0] GAIN_Q30     = 33'sd652032875;

    typedef enum logic [0:0] {
        REG_SECTOR_COUNT = 1'b0,
        REG_STACK_COUNT  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic valid;
        logic err;
    } t_ctl;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } t_cstate;

    typedef struct packed {
        t_cstate    st;
        t_cstate    se;
        logic [1:0] quad_st;
        logic [1:0] quad_se;
    } t_cpair;

    // Clamp a count into its usable range.
    function automatic logic [8:0] eff_count(input logic [8:0] v, input logic [8:0] lo);
        logic [8:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > 9'(MAX_DIVISIONS)) begin
            r = 9'(MAX_DIVISIONS);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // One restoring long-division step: returns {quotient bit, new remainder}.
    function automatic logic [9:0] div_step(input logic [8:0] r, input logic [8:0] d);
        logic [9:0] r2;
        logic [9:0] diff;
        r2   = {r, 1'b0};
        diff = r2 - {1'b0, d};
        if (r2 >= {1'b0, d}) begin
            return {1'b1, diff[8:0]};
        end else begin
            return {1'b0, r2[8:0]};
        end
    endfunction

    // Arctangent of 2^-k in units of 2^-32 turn.
    function automatic logic signed [32:0] atan_turn(input int k);
        logic signed [32:0] a;
        case (k)
            0:  a = 33'sh020000000;
            1:  a = 33'sh012E4051E;
            2:  a = 33'sh009FB385B;
            3:  a = 33'sh0051111D4;
            4:  a = 33'sh0028B0D43;
            5:  a = 33'sh00145D7E1;
            6:  a = 33'sh000A2F61E;
            7:  a = 33'sh000517C55;
            8:  a = 33'sh00028BE53;
            9:  a = 33'sh000145F2F;
            10: a = 33'sh0000A2F98;
            11: a = 33'sh0000517CC;
            12: a = 33'sh000028BE6;
            13: a = 33'sh0000145F3;
            14: a = 33'sh00000A2F9;
            15: a = 33'sh00000517C;
            default: a = '0;
        endcase
        return a;
    endfunction

    // One rotation step of the CORDIC.
    function automatic t_cstate cordic_iter(input t_cstate s, input int k);
        t_cstate            o;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        dx = s.y >>> k;
        dy = s.x >>> k;
        if (s.z >= 0) begin
            o.x = s.x - dx;
            o.y = s.y + dy;
            o.z = s.z - atan_turn(k);
        end else begin
            o.x = s.x + dx;
            o.y = s.y - dy;
            o.z = s.z + atan_turn(k);
        end
        return o;
    endfunction

endpackage

[design/svg_in_if.sv]
// Input channel: one grid point per word.
`timescale 1ns / 1ps
interface svg_in_if;
    logic       valid;
    logic       ready;
    logic [8:0] stack_index;
    logic [8:0] sector_index;

    modport source (output valid, output stack_index, output sector_index, input ready);
    modport sink   (input valid, input stack_index, input sector_index, output ready);
endinterface

[design/svg_out_if.sv]
// Output channel: one vertex per word.
`timescale 1ns / 1ps
interface svg_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] pos_x;
    logic signed [14:0] pos_y;
    logic signed [14:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               index_error;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output norm_x, output norm_y, output norm_z,
                    output index_error, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input norm_x, input norm_y, input norm_z,
                    input index_error, output ready);
endinterface

[design/svg_divider.sv]
// Pipelined long division of both grid indices into turn fractions, two bits per stage.
`timescale 1ns / 1ps
module svg_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [8:0]          i_stack_index,
    input  logic [8:0]          i_sector_index,
    input  logic [8:0]          i_stacks,
    input  logic [8:0]          i_sectors,
    output svg_pkg::t_ctl       o_ctl,
    output logic [31:0]         o_phase_st,
    output logic [31:0]         o_phase_se
);
    import svg_pkg::*;

    t_ctl        r_ctl   [DIV_STAGES];
    logic [8:0]  r_rem_st[DIV_STAGES];
    logic [8:0]  r_rem_se[DIV_STAGES];
    logic [32:0] r_q_st  [DIV_STAGES];
    logic [31:0] r_q_se  [DIV_STAGES];

    t_ctl        n_ctl   [DIV_STAGES];
    logic [8:0]  n_rem_st[DIV_STAGES];
    logic [8:0]  n_rem_se[DIV_STAGES];
    logic [32:0] n_q_st  [DIV_STAGES];
    logic [31:0] n_q_se  [DIV_STAGES];

    // Stage zero seeds the remainders; an index equal to its count gives a whole turn.
    logic        st_full;
    logic        se_full;
    logic        in_err;
    always_comb begin
        st_full = (i_stack_index == i_stacks);
        se_full = (i_sector_index == i_sectors);
        in_err  = (i_stack_index > i_stacks) || (i_sector_index > i_sectors);
    end

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++) begin : g_stage
            t_ctl        p_ctl;
            logic [8:0]  p_rs;
            logic [8:0]  p_re;
            logic [32:0] p_qs;
            logic [31:0] p_qe;

            if (g == 0) begin : g_seed
                always_comb begin
                    p_ctl = '{valid: i_valid, err: in_err};
                    p_rs  = (st_full || in_err) ? 9'd0 : i_stack_index;
                    p_re  = (se_full || in_err) ? 9'd0 : i_sector_index;
                    p_qs  = {32'd0, st_full};
                    p_qe  = '0;
                end
            end else begin : g_chain
                always_comb begin
                    p_ctl = r_ctl[g-1];
                    p_rs  = r_rem_st[g-1];
                    p_re  = r_rem_se[g-1];
                    p_qs  = r_q_st[g-1];
                    p_qe  = r_q_se[g-1];
                end
            end

            always_comb begin
                logic [9:0]  a;
                logic [9:0]  b;
                logic [9:0]  c;
                logic [9:0]  d;
                n_ctl[g]    = p_ctl;
                a = div_step(p_rs, i_stacks);
                b = div_step(a[8:0], i_stacks);
                c = div_step(p_re, i_sectors);
                d = div_step(c[8:0], i_sectors);
                n_rem_st[g] = b[8:0];
                n_rem_se[g] = d[8:0];
                n_q_st[g]   = {p_qs[30:0], a[9], b[9]};
                n_q_se[g]   = {p_qe[29:0], c[9], d[9]};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ctl[g] <= '0;
                end else if (i_en) begin
                    r_ctl[g] <= n_ctl[g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem_st[g] <= n_rem_st[g];
                    r_rem_se[g] <= n_rem_se[g];
                    r_q_st[g]   <= n_q_st[g];
                    r_q_se[g]   <= n_q_se[g];
                end
            end
        end
    endgenerate

    // The stack angle runs down from a quarter turn by half the stack fraction.
    assign o_ctl      = r_ctl[DIV_STAGES-1];
    assign o_phase_st = QUARTER_TURN - r_q_st[DIV_STAGES-1][32:1];
    assign o_phase_se = r_q_se[DIV_STAGES-1];
endmodule

[design/svg_cordic.sv]
// Two CORDIC rotators side by side, two iterations per pipeline stage.
`timescale 1ns / 1ps
module svg_cordic (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  svg_pkg::t_ctl   i_ctl,
    input  logic [31:0]     i_phase_st,
    input  logic [31:0]     i_phase_se,
    output svg_pkg::t_ctl   o_ctl,
    output svg_pkg::t_cpair o_pair
);
    import svg_pkg::*;

    t_ctl   r_ctl [CORDIC_STAGES];
    t_cpair r_pair[CORDIC_STAGES];
    t_cpair n_pair[CORDIC_STAGES];

    t_cpair seed;
    always_comb begin
        seed.st      = '{x: GAIN_Q30, y: '0, z: {3'b000, i_phase_st[29:0]}};
        seed.se      = '{x: GAIN_Q30, y: '0, z: {3'b000, i_phase_se[29:0]}};
        seed.quad_st = i_phase_st[31:30];
        seed.quad_se = i_phase_se[31:30];
    end

    genvar g;
    generate
        for (g = 0; g < CORDIC_STAGES; g++) begin : g_stage
            t_cpair p_pair;
            t_ctl   p_ctl;

            if (g == 0) begin : g_seed
                assign p_pair = seed;
                assign p_ctl  = i_ctl;
            end else begin : g_chain
                assign p_pair = r_pair[g-1];
                assign p_ctl  = r_ctl[g-1];
            end

            always_comb begin
                n_pair[g]    = p_pair;
                n_pair[g].st = cordic_iter(cordic_iter(p_pair.st, 2 * g), 2 * g + 1);
                n_pair[g].se = cordic_iter(cordic_iter(p_pair.se, 2 * g), 2 * g + 1);
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ctl[g] <= '0;
                end else if (i_en) begin
                    r_ctl[g] <= p_ctl;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pair[g] <= n_pair[g];
                end
            end
        end
    endgenerate

    assign o_ctl  = r_ctl[CORDIC_STAGES-1];
    assign o_pair = r_pair[CORDIC_STAGES-1];
endmodule

[design/svg_output.sv]
// Quadrant fold, normal products, rounding, saturation and the output register.
`timescale 1ns / 1ps
module svg_output (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  svg_pkg::t_ctl      i_ctl,
    input  svg_pkg::t_cpair    i_pair,
    output logic               o_valid,
    output logic signed [14:0] o_pos_x,
    output logic signed [14:0] o_pos_y,
    output logic signed [14:0] o_pos_z,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic signed [15:0] o_norm_z,
    output logic               o_index_error
);
    import svg_pkg::*;

    localparam int POS_SH  = 61 - FRAC_BITS;
    localparam int NORM_SH = 60 - FRAC_BITS;
    localparam int SPOS_SH = 31 - FRAC_BITS;
    localparam int SNRM_SH = 30 - FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;

    // Fold the quadrant back into cosine and sine.
    function automatic logic [63:0] fold(input t_cstate s, input logic [1:0] q);
        logic signed [31:0] c;
        logic signed [31:0] sn;
        case (q)
            2'd0:    begin c = 32'(s.x);  sn = 32'(s.y);  end
            2'd1:    begin c = 32'(-s.y); sn = 32'(s.x);  end
            2'd2:    begin c = 32'(-s.x); sn = 32'(-s.y); end
            default: begin c = 32'(s.y);  sn = 32'(-s.x); end
        endcase
        return {c, sn};
    endfunction

    function automatic logic signed [63:0] rnd_sat(input logic signed [63:0] v,
                                                   input int sh,
                                                   input logic signed [63:0] lim);
        logic signed [63:0] t;
        t = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        if (t > lim) begin
            t = lim;
        end else if (t < -lim) begin
            t = -lim;
        end
        return t;
    endfunction

    t_ctl               r_ctl_a;
    logic signed [63:0] r_nx;
    logic signed [63:0] r_ny;
    logic signed [31:0] r_sst;

    logic [63:0]        cs_st;
    logic [63:0]        cs_se;
    logic signed [31:0] cst;
    logic signed [31:0] sst;
    logic signed [31:0] cse;
    logic signed [31:0] sse;
    always_comb begin
        cs_st = fold(i_pair.st, i_pair.quad_st);
        cs_se = fold(i_pair.se, i_pair.quad_se);
        cst   = cs_st[63:32];
        sst   = cs_st[31:0];
        cse   = cs_se[63:32];
        sse   = cs_se[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
        end else if (i_en) begin
            r_ctl_a <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx  <= cst * cse;
            r_ny  <= cst * sse;
            r_sst <= sst;
        end
    end

    logic signed [63:0] sst_w;
    logic signed [14:0] n_pos_x;
    logic signed [14:0] n_pos_y;
    logic signed [14:0] n_pos_z;
    logic signed [15:0] n_norm_x;
    logic signed [15:0] n_norm_y;
    logic signed [15:0] n_norm_z;
    always_comb begin
        sst_w    = 64'(r_sst);
        n_pos_x  = 15'(rnd_sat(r_nx, POS_SH, HALF));
        n_pos_y  = 15'(rnd_sat(r_ny, POS_SH, HALF));
        n_pos_z  = 15'(rnd_sat(sst_w, SPOS_SH, HALF));
        n_norm_x = 16'(rnd_sat(r_nx, NORM_SH, ONE));
        n_norm_y = 16'(rnd_sat(r_ny, NORM_SH, ONE));
        n_norm_z = 16'(rnd_sat(sst_w, SNRM_SH, ONE));
        if (r_ctl_a.err) begin
            n_pos_x  = '0;
            n_pos_y  = '0;
            n_pos_z  = '0;
            n_norm_x = '0;
            n_norm_y = '0;
            n_norm_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_ctl_a.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_pos_x       <= n_pos_x;
            o_pos_y       <= n_pos_y;
            o_pos_z       <= n_pos_z;
            o_norm_x      <= n_norm_x;
            o_norm_y      <= n_norm_y;
            o_norm_z      <= n_norm_z;
            o_index_error <= r_ctl_a.err;
        end
    end
endmodule

[design/sphere_vertex_generator_unit.sv]
// Top level of the UV-sphere vertex generator.
`timescale 1ns / 1ps
// Each input word names a grid point by stack and sector index and produces one output
// word with the vertex position (radius one half) in Q1.14 and unit normal in Q2.14. The
// block accepts a new word every cycle unless the output stalls. Inside, 16 stages of a
// two-bit-per-stage long divider turn the indices into 32-bit turn fractions, 8 stages
// of two CORDIC rotators (two iterations each) produce cosine and sine, one stage forms
// the normal products and the last stage rounds, saturates and holds the output word.
// The whole pipeline advances together whenever the output register is empty or being
// taken, so a stall at the output holds every stage in place. An index above its count
// returns a word with index_error set and all vector fields zero. Counts below their
// minimum (3 sectors, 2 stacks) or above 256 are clamped. Write the count registers
// only while no word is in flight.
module sphere_vertex_generator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    svg_in_if.sink             i_word,
    svg_out_if.source          o_word,
    input  logic               i_cfg_we,
    input  svg_pkg::t_reg_idx  i_cfg_idx,
    input  logic [8:0]         i_cfg_data
);
    import svg_pkg::*;

    logic [8:0] r_sector_count;
    logic [8:0] r_stack_count;

    // Configuration writes land directly in the count registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_count <= 9'd36;
            r_stack_count  <= 9'd18;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SECTOR_COUNT: r_sector_count <= i_cfg_data;
                REG_STACK_COUNT:  r_stack_count  <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    logic [8:0] stacks;
    logic [8:0] sectors;
    assign stacks  = eff_count(r_stack_count, 9'(MIN_STACKS));
    assign sectors = eff_count(r_sector_count, 9'(MIN_SECTORS));

    // The pipeline moves when the output word is absent or consumed this cycle.
    logic en;
    assign en           = !o_word.valid || o_word.ready;
    assign i_word.ready = en;

    t_ctl        div_ctl;
    logic [31:0] phase_st;
    logic [31:0] phase_se;

    svg_divider u_divider (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_word.valid),
        .i_stack_index  (i_word.stack_index),
        .i_sector_index (i_word.sector_index),
        .i_stacks       (stacks),
        .i_sectors      (sectors),
        .o_ctl          (div_ctl),
        .o_phase_st     (phase_st),
        .o_phase_se     (phase_se)
    );

    t_ctl   cor_ctl;
    t_cpair cor_pair;

    svg_cordic u_cordic (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_ctl      (div_ctl),
        .i_phase_st (phase_st),
        .i_phase_se (phase_se),
        .o_ctl      (cor_ctl),
        .o_pair     (cor_pair)
    );

    svg_output u_output (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_ctl         (cor_ctl),
        .i_pair        (cor_pair),
        .o_valid       (o_word.valid),
        .o_pos_x       (o_word.pos_x),
        .o_pos_y       (o_word.pos_y),
        .o_pos_z       (o_word.pos_z),
        .o_norm_x      (o_word.norm_x),
        .o_norm_y      (o_word.norm_y),
        .o_norm_z      (o_word.norm_z),
        .o_index_error (o_word.index_error)
    );
endmodule

[design/svg_checker.sv]
// Port-level checks of the sphere vertex generator, bound to the top level.
`timescale 1ns / 1ps
module svg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_in_ready,
    input logic signed [14:0] i_pos_x,
    input logic signed [15:0] i_norm_x,
    input logic signed [15:0] i_norm_z,
    input logic               i_index_error
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_index_error |-> i_pos_x == 0 && i_norm_x == 0 && i_norm_z == 0)
        else $error("error word carries nonzero vector");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_norm_z <= 16'sd16384 && i_norm_z >= -16'sd16384)
        else $error("normal z out of range");

    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while pipeline stalled");
endmodule

bind sphere_vertex_generator_unit svg_checker u_svg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_word.valid),
    .i_out_ready   (o_word.ready),
    .i_in_ready    (i_word.ready),
    .i_pos_x       (o_word.pos_x),
    .i_norm_x      (o_word.norm_x),
    .i_norm_z      (o_word.norm_z),
    .i_index_error (o_word.index_error)
);
